@@ hw/rtl/signed_int_to_decimal_ascii_top_assert.svh @@
// Assertion macros for the signed integer to decimal ASCII block
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define SIDA_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// next-cycle implication
`define SIDA_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

@@ hw/rtl/sida_pkg.sv @@
// Package: shared constants for the decimal ASCII converter
`default_nettype none
package sida_pkg;
	localparam logic [5:0] CH_ZERO  = 6'd48;
	localparam logic [5:0] CH_MINUS = 6'd45;
	localparam logic [3:0] RADIX    = 4'd10;
endpackage
`default_nettype wire

@@ hw/rtl/signed_int_to_decimal_ascii_top.sv @@
// Top level: signed integer to decimal ASCII character stream
// Usage:
//   Input channel value/value_valid/value_ready carries one signed integer
//   per transfer; only the low VALUE_BITS bits count, bit VALUE_BITS-1 is sign.
//   Output channel character/last/out_valid/out_ready carries one ASCII
//   character per transfer, most significant digit first, last on the
//   final one; a negative number is preceded by '-'.
//   An input register forms sign and magnitude, then one pipeline stage per
//   decimal digit (ND, 10 at 32 bits) extracts a digit by compare and subtract.
//   A character register streams the text out one character per cycle while
//   out_ready is high. Throughput: one input per cycle while the pipeline has
//   room; the output streams L characters per item (at most 11 at 32 bits).
//   The pipeline holds ND+1 items plus the one being streamed.
//   Reset clears all valid bits; no item is in flight afterwards.
//   A receiver stall holds the current character and backs up the pipeline
//   stage by stage until value_ready drops; nothing is lost.
`default_nettype none
`include "signed_int_to_decimal_ascii_top_assert.svh"
module signed_int_to_decimal_ascii_top #(
	parameter int VALUE_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [31:0] value,
	input  wire logic        value_valid,
	output logic             value_ready,
	output logic [5:0]       character,
	output logic             last,
	output logic             out_valid,
	input  wire logic        out_ready
);
	import sida_pkg::*;

	function automatic int digits_of(input int w);
		logic [63:0] m;
		logic [63:0] p;
		int          n;
		m = 64'd1 << (w - 1);
		p = 64'd1;
		n = 1;
		while (p * 64'(RADIX) <= m) begin
			p = p * 64'(RADIX);
			n++;
		end
		return n;
	endfunction

	localparam int W  = VALUE_BITS;
	localparam int ND = digits_of(W);
	localparam int NW = $clog2(ND + 1);
	localparam int IW = $clog2(ND);

	logic               vld_s1;
	logic               neg_s1;
	logic [W-1:0]       mag_s1;
	logic [W-1:0]       raw;
	logic [63:0]        ext;
	logic               stg_valid [ND+1];
	logic               stg_ready [ND+1];
	logic               stg_neg   [ND+1];
	logic [W-1:0]       stg_mag   [ND+1];
	logic [ND-1:0][3:0] stg_dig   [ND+1];
	logic [NW-1:0]      stg_nsig  [ND+1];
	logic               sign_pend_q;
	logic [IW-1:0]      idx_q;
	logic [ND-1:0][3:0] dig_q;

	assign ext = {32'd0, value};
	assign raw = ext[W-1:0];
	assign value_ready = !vld_s1 || stg_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (value_ready) begin
			vld_s1 <= value_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (value_valid && value_ready) begin
			neg_s1 <= raw[W-1];
			mag_s1 <= raw[W-1] ? (~raw + W'(1)) : raw;
		end
	end

	assign stg_valid[0]  = vld_s1;
	assign stg_neg[0]    = neg_s1;
	assign stg_mag[0]    = mag_s1;
	assign stg_dig[0]    = '0;
	assign stg_nsig[0]   = '0;
	assign stg_ready[ND] = !out_valid;

	for (genvar j = 0; j < ND; j++) begin : g_digit
		sida_divstep #(.W(W), .ND(ND), .NW(NW), .K(ND - 1 - j)) u_digit (
			.clk(clk), .arst_n(arst_n),
			.in_valid(stg_valid[j]), .in_ready(stg_ready[j]),
			.in_neg(stg_neg[j]), .in_mag(stg_mag[j]),
			.in_dig(stg_dig[j]), .in_nsig(stg_nsig[j]),
			.out_valid(stg_valid[j+1]), .out_ready(stg_ready[j+1]),
			.out_neg(stg_neg[j+1]), .out_mag(stg_mag[j+1]),
			.out_dig(stg_dig[j+1]), .out_nsig(stg_nsig[j+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid   <= 1'b0;
			sign_pend_q <= 1'b0;
			idx_q       <= '0;
		end else if (!out_valid) begin
			if (stg_valid[ND]) begin
				out_valid   <= 1'b1;
				sign_pend_q <= stg_neg[ND];
				idx_q       <= (stg_nsig[ND] == '0) ? '0 : IW'(stg_nsig[ND] - 1'b1);
			end
		end else if (out_ready) begin
			if (sign_pend_q) begin
				sign_pend_q <= 1'b0;
			end else if (idx_q == '0) begin
				out_valid <= 1'b0;
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid && stg_valid[ND])
			dig_q <= stg_dig[ND];
	end

	assign character = sign_pend_q ? CH_MINUS : (CH_ZERO + {2'b00, dig_q[idx_q]});
	assign last = !sign_pend_q && (idx_q == '0);

	`SIDA_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(character))
	`SIDA_ASSERT_NXT(a_last_ends, clk, arst_n, out_valid && out_ready && last, !out_valid)
	`SIDA_ASSERT_IMP(a_digit_range, clk, arst_n, out_valid && !sign_pend_q, dig_q[idx_q] <= 4'd9)
	`SIDA_ASSERT_IMP(a_sign_not_last, clk, arst_n, out_valid && sign_pend_q, !last)
endmodule
`default_nettype wire

@@ hw/rtl/sida_divstep.sv @@
// One decimal digit stage of the conversion pipeline: digit K by compare and subtract
`default_nettype none
module sida_divstep #(
	parameter int W  = 32,
	parameter int ND = 10,
	parameter int NW = 4,
	parameter int K  = 0
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               in_neg,
	input  wire logic [W-1:0]       in_mag,
	input  wire logic [ND-1:0][3:0] in_dig,
	input  wire logic [NW-1:0]      in_nsig,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    out_neg,
	output logic [W-1:0]            out_mag,
	output logic [ND-1:0][3:0]      out_dig,
	output logic [NW-1:0]           out_nsig
);
	import sida_pkg::*;
	localparam int PW = W + 4;

	function automatic logic [PW-1:0] pow10(input int k);
		logic [PW-1:0] p;
		p = PW'(1);
		for (int i = 0; i < k; i++)
			p = p * PW'(RADIX);
		return p;
	endfunction

	localparam logic [PW-1:0] STEP = pow10(K);

	logic [PW-1:0]      ext;
	logic [PW-1:0]      sub;
	logic [PW-1:0]      rest;
	logic [3:0]         d;
	logic [ND-1:0][3:0] dig_n;
	logic [NW-1:0]      nsig_n;

	assign ext      = {4'd0, in_mag};
	assign rest     = ext - sub;
	assign in_ready = !out_valid || out_ready;

	always_comb begin
		d   = 4'd0;
		sub = '0;
		for (int i = 1; i < int'(RADIX); i++) begin
			if (ext >= PW'(i) * STEP) begin
				d   = 4'(i);
				sub = PW'(i) * STEP;
			end
		end
	end

	always_comb begin
		dig_n    = in_dig;
		dig_n[K] = d;
		nsig_n   = in_nsig;
		if (in_nsig == '0 && d != 4'd0)
			nsig_n = NW'(K + 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			out_neg  <= in_neg;
			out_mag  <= rest[W-1:0];
			out_dig  <= dig_n;
			out_nsig <= nsig_n;
		end
	end
endmodule
`default_nettype wire

@@ test/signed_int_to_decimal_ascii_top_tb.sv @@
// Testbench: signed integer to decimal ASCII converter, checked against a predictor
`timescale 1ns / 1ps
module signed_int_to_decimal_ascii_top_tb;
	import sida_pkg::*;

	typedef struct packed {
		logic [5:0] ch;
		logic       fin;
	} text_char_t;

	typedef struct {
		logic [31:0] val;
		bit          typed;
		text_char_t  first;
		int          count;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic [31:0] value;
	logic        value_valid;
	logic        value_ready;
	logic [5:0]  character;
	logic        last;
	logic        out_valid;
	logic        out_ready;

	text_char_t  text_queue[$];
	int          mismatches;
	int          rows_seen;
	bit          stim_done;
	bit          hold_go;
	bit          hold_off;
	row_t        rows[$];

	signed_int_to_decimal_ascii_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.value_valid(value_valid),
		.value_ready(value_ready),
		.character  (character),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic queue_decimal_text(input logic [31:0] v, output int n);
		logic [31:0] mag;
		logic [3:0]  digs[$];
		text_char_t  c;
		mag = v;
		n = 0;
		if (v[31]) begin
			mag = ~v + 32'd1;
			c.ch = CH_MINUS;
			c.fin = 1'b0;
			text_queue.push_back(c);
			n++;
		end
		do begin
			digs.push_front(4'(mag % 32'd10));
			mag = mag / 32'd10;
		end while (mag != 0);
		foreach (digs[i]) begin
			c.ch = CH_ZERO + 6'(digs[i]);
			c.fin = (i == digs.size() - 1);
			text_queue.push_back(c);
			n++;
		end
	endtask

	task automatic add_row(input logic [31:0] v, input bit t, input logic [5:0] ch,
			input logic f, input int cnt);
		row_t r;
		r.val = v;
		r.typed = t;
		r.first.ch = ch;
		r.first.fin = f;
		r.count = cnt;
		rows.push_back(r);
	endtask

	task automatic send_value(input logic [31:0] v);
		int gap;
		gap = $urandom_range(0, 7);
		if (gap != 0) begin
			value_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		value <= v;
		value_valid <= 1'b1;
		@(posedge clk);
		while (!value_ready) @(posedge clk);
	endtask

	// fill the expectation queue at transfer time
	always @(posedge clk) begin
		int n;
		if (value_valid && value_ready) begin
			int base;
			base = text_queue.size();
			queue_decimal_text(value, n);
			if (rows_seen < rows.size() && rows[rows_seen].typed) begin
				if (text_queue[base] !== rows[rows_seen].first || n != rows[rows_seen].count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("row %0d expected %0d/%0b count %0d got %0d/%0b count %0d",
							rows_seen, rows[rows_seen].first.ch, rows[rows_seen].first.fin,
							rows[rows_seen].count, text_queue[base].ch,
							text_queue[base].fin, n);
				end
			end
			rows_seen++;
		end
	end

	always @(posedge clk) begin
		text_char_t exp;
		if (out_valid && out_ready) begin
			if (text_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected character %0d last %0b", character, last);
			end else begin
				exp = text_queue.pop_front();
				if (character !== exp.ch || last !== exp.fin) begin
					mismatches++;
					if (mismatches <= 10)
						$display("expected %0d/%0b got %0d/%0b", exp.ch, exp.fin,
							character, last);
				end
			end
		end
	end

	// long receiver stall
	initial begin
		hold_off = 1'b0;
		wait (hold_go);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (300) @(posedge clk);
		hold_off = 1'b0;
	end

	// receiver
	initial begin
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = stim_done ? 0 : $urandom_range(0, 7);
			if (gap != 0 || hold_off) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
				while (hold_off) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin
		logic [31:0] v;
		int sh;
		value = '0;
		value_valid = 1'b0;
		arst_n = 1'b0;
		mismatches = 0;
		rows_seen = 0;
		stim_done = 1'b0;
		hold_go = 1'b0;
		add_row(32'd0, 1, CH_ZERO, 1'b1, 1);
		add_row(32'h8000_0000, 1, CH_MINUS, 1'b0, 11);
		add_row(32'h7FFF_FFFF, 1, CH_ZERO + 6'd2, 1'b0, 10);
		add_row(32'hFFFF_FFFF, 1, CH_MINUS, 1'b0, 2);
		add_row(32'd1, 1, CH_ZERO + 6'd1, 1'b1, 1);
		add_row(32'd9, 1, CH_ZERO + 6'd9, 1'b1, 1);
		add_row(32'd10, 0, '0, 0, 0);
		add_row(32'd1000000000, 0, '0, 0, 0);
		add_row(-32'sd10, 0, '0, 0, 0);
		add_row(-32'sd999999999, 0, '0, 0, 0);
		add_row(32'h5555_5555, 0, '0, 0, 0);
		add_row(32'hAAAA_AAAA, 0, '0, 0, 0);
		add_row(32'd4294967286, 0, '0, 0, 0);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) send_value(rows[i].val);
		hold_go = 1'b1;
		for (int i = 0; i < 180; i++) begin
			v = $urandom();
			sh = $urandom_range(0, 31);
			if ($urandom_range(0, 1)) v = 32'($signed(v) >>> sh);
			send_value(v);
		end
		value_valid <= 1'b0;
		stim_done = 1'b1;
		@(posedge clk);
		while (text_queue.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (mismatches == 0 && text_queue.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/sida_pkg.sv
hw/rtl/sida_divstep.sv
hw/rtl/signed_int_to_decimal_ascii_top.sv
test/signed_int_to_decimal_ascii_top_tb.sv
